>>> rtl/bps_pkg.sv
// Shared types, request codes and pattern tables for the buzzer pattern sequencer.
package bps_pkg;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_PLAY = 2'd1;
  localparam logic [1:0] REQ_STOP = 2'd2;

  localparam logic [2:0] PAT_CHIRP  = 3'd0;
  localparam logic [2:0] PAT_DOUBLE = 3'd1;
  localparam logic [2:0] PAT_TRIPLE = 3'd2;
  localparam logic [2:0] PAT_ALARM  = 3'd3;
  localparam logic [2:0] PAT_SOLID  = 3'd4;

  localparam logic [6:0] MAX_VOLUME = 7'd100;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] preset;
    logic [6:0] volume;
  } bps_in_t;

  typedef struct packed {
    logic       buzzer_on;
    logic [6:0] drive_volume;
    logic       is_playing;
    logic       status;
  } bps_out_t;

  // Sequencer state apart from the phase down-counter, whose width is a parameter.
  typedef struct packed {
    logic [2:0] active_pattern;
    logic [1:0] step_index;
    logic       in_on_phase;
    logic       playing;
    logic [6:0] held_volume;
  } bps_state_t;

  // On-duration in milliseconds of a step; the solid pattern is handled by pat_forever.
  function automatic logic [7:0] pat_on_ms(input logic [2:0] p, input logic [1:0] s);
    logic [7:0] d;
    d = 8'd0;
    case (p)
      PAT_CHIRP:  d = (s == 2'd0) ? 8'd50 : 8'd0;
      PAT_DOUBLE: d = (s <= 2'd1) ? 8'd100 : 8'd0;
      PAT_TRIPLE: d = (s <= 2'd2) ? 8'd100 : 8'd0;
      PAT_ALARM:  d = (s == 2'd0) ? 8'd200 : 8'd0;
      default:    d = 8'd0;
    endcase
    return d;
  endfunction

  // True where the step's on-phase is all ones and never runs out.
  function automatic logic pat_forever(input logic [2:0] p, input logic [1:0] s);
    return (p == PAT_SOLID) && (s == 2'd0);
  endfunction

  function automatic logic [7:0] pat_off_ms(input logic [2:0] p, input logic [1:0] s);
    logic [7:0] d;
    d = 8'd0;
    case (p)
      PAT_DOUBLE: d = (s == 2'd0) ? 8'd100 : 8'd0;
      PAT_TRIPLE: d = (s <= 2'd1) ? 8'd100 : 8'd0;
      PAT_ALARM:  d = (s == 2'd0) ? 8'd200 : 8'd0;
      default:    d = 8'd0;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] pat_steps(input logic [2:0] p);
    logic [1:0] n;
    case (p)
      PAT_DOUBLE: n = 2'd2;
      PAT_TRIPLE: n = 2'd3;
      default:    n = 2'd1;
    endcase
    return n;
  endfunction

  function automatic logic pat_loops(input logic [2:0] p);
    return p == PAT_ALARM;
  endfunction

  function automatic logic pat_valid(input logic [2:0] p);
    return p <= PAT_SOLID;
  endfunction

endpackage

>>> rtl/buzzer_pattern_sequencer.sv
// A result appears in the output register in the cycle after its request is accepted.
// One request per clock unless stalled; the state update and result are one register stage.
// A request is taken while a result waits, as long as the output register is free or drains.
// Reset (synchronous, active low) silences the buzzer, clears all pattern state and
// empties the output register.
module buzzer_pattern_sequencer #(
  parameter int DURATION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bps_pkg::bps_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bps_pkg::bps_out_t out_data
);
  import bps_pkg::*;

  bps_state_t               state_r;
  bps_state_t               state_nxt;
  logic [DURATION_BITS-1:0] rem_r;
  logic [DURATION_BITS-1:0] rem_nxt;
  bps_out_t                 res_nxt;
  bps_out_t                 res_r;
  logic                     out_valid_r;
  logic                     accept;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  bps_step #(
    .DURATION_BITS(DURATION_BITS)
  ) u_step (
    .req     (in_data),
    .cur     (state_r),
    .rem     (rem_r),
    .nxt     (state_nxt),
    .rem_nxt (rem_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
        rem_r   <= rem_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> rtl/bps_step.sv
// Next-state and result logic for one request of the buzzer pattern sequencer.
module bps_step #(
  parameter int DURATION_BITS = 16
) (
  input  bps_pkg::bps_in_t                req,
  input  bps_pkg::bps_state_t             cur,
  input  logic [DURATION_BITS-1:0]        rem,
  output bps_pkg::bps_state_t             nxt,
  output logic [DURATION_BITS-1:0]        rem_nxt,
  output bps_pkg::bps_out_t               res
);
  import bps_pkg::*;

  localparam logic [DURATION_BITS-1:0] DUR_ALL_ONES = {DURATION_BITS{1'b1}};

  logic [2:0]               pat;
  logic [2:0]               step_inc;
  logic [1:0]               step_next;
  logic                     stop_now;
  logic [7:0]               gap_ms;
  logic [DURATION_BITS-1:0] next_on;
  logic [DURATION_BITS-1:0] start_on;
  logic                     status;

  always_comb begin
    pat       = pat_valid(cur.active_pattern) ? cur.active_pattern : PAT_CHIRP;
    gap_ms    = pat_off_ms(pat, cur.step_index);
    step_inc  = {1'b0, cur.step_index} + 3'd1;
    stop_now  = 1'b0;
    step_next = step_inc[1:0];
    if (step_inc >= {1'b0, pat_steps(pat)}) begin
      if (pat_loops(pat)) begin
        step_next = 2'd0;
      end else begin
        stop_now = 1'b1;
      end
    end
    next_on = pat_forever(pat, step_next) ? DUR_ALL_ONES
                                          : DURATION_BITS'(pat_on_ms(pat, step_next));
    start_on = pat_forever(req.preset, 2'd0) ? DUR_ALL_ONES
                                             : DURATION_BITS'(pat_on_ms(req.preset, 2'd0));
  end

  always_comb begin
    nxt     = cur;
    rem_nxt = rem;
    status  = 1'b0;
    case (req.req_type)
      REQ_TICK: begin
        if (cur.playing) begin
          if (cur.in_on_phase && rem == DUR_ALL_ONES) begin
            rem_nxt = rem;
          end else if (rem <= DURATION_BITS'(1)) begin
            // Phase over: off gap if there is one, otherwise the next step or the end of the pattern.
            if (cur.in_on_phase && gap_ms != 8'd0) begin
              nxt.in_on_phase = 1'b0;
              rem_nxt         = DURATION_BITS'(gap_ms);
            end else if (stop_now) begin
              nxt.playing = 1'b0;
            end else begin
              nxt.step_index  = step_next;
              nxt.in_on_phase = 1'b1;
              rem_nxt         = next_on;
            end
          end else begin
            rem_nxt = rem - DURATION_BITS'(1);
          end
        end
      end
      REQ_PLAY: begin
        if (pat_valid(req.preset)) begin
          nxt.active_pattern = req.preset;
          nxt.step_index     = 2'd0;
          nxt.in_on_phase    = 1'b1;
          nxt.playing        = 1'b1;
          nxt.held_volume    = (req.volume > MAX_VOLUME) ? MAX_VOLUME : req.volume;
          rem_nxt            = start_on;
        end else begin
          nxt.playing = 1'b0;
          status      = 1'b1;
        end
      end
      REQ_STOP: begin
        nxt.playing = 1'b0;
      end
      default: begin
        nxt = cur;
      end
    endcase

    res.buzzer_on    = nxt.playing & nxt.in_on_phase;
    res.drive_volume = nxt.held_volume;
    res.is_playing   = nxt.playing;
    res.status       = status;
  end

endmodule

>>> bench/buzzer_pattern_sequencer_test.sv
// Self-checking testbench for the buzzer pattern sequencer, with its own tone predictor.
module buzzer_pattern_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bps_pkg::*;

  localparam int DUR_W = 16;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int REQUEST_TARGET = 1550;
  localparam int IDLE_LIMIT = 500;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [DUR_W-1:0] DUR_FOREVER = {DUR_W{1'b1}};

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  bps_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bps_out_t out_data;

  bps_in_t  request_queue[$];
  bps_out_t predicted_outputs[$];

  // Predicted sequencer state; the phase counter is kept apart because of its width.
  bps_state_t       tone = '0;
  logic [DUR_W-1:0] phase_ms = '0;

  int requests_built = 0;
  int requests_taken = 0;
  int results_checked = 0;
  int failures = 0;
  int plays = 0;
  int invalid_plays = 0;
  int stops = 0;
  int pattern_ends = 0;
  int alarm_wraps = 0;

  int   send_wait = 0;
  logic send_burst = 1'b0;
  int   recv_wait = 0;
  logic recv_burst = 1'b0;
  int   idle_cycles = 0;

  function automatic int beep_count(input logic [2:0] p);
    case (p)
      PAT_DOUBLE: return 2;
      PAT_TRIPLE: return 3;
      default:    return 1;
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] beep_ms(input logic [2:0] p, input int s);
    if (s >= beep_count(p)) return '0;
    case (p)
      PAT_CHIRP: return DUR_W'(50);
      PAT_ALARM: return DUR_W'(200);
      PAT_SOLID: return DUR_FOREVER;
      default:   return DUR_W'(100);
    endcase
  endfunction

  // Double/triple beeps are 100 ms apart, none after the last; an alarm beep gets 200 ms.
  function automatic logic [DUR_W-1:0] gap_ms(input logic [2:0] p, input int s);
    case (p)
      PAT_ALARM:              return (s == 0) ? DUR_W'(200) : '0;
      PAT_DOUBLE, PAT_TRIPLE: return (s + 1 < beep_count(p)) ? DUR_W'(100) : '0;
      default:                return '0;
    endcase
  endfunction

  task automatic next_beep();
    int s;
    s = int'(tone.step_index) + 1;
    if (s >= beep_count(tone.active_pattern)) begin
      if (tone.active_pattern == PAT_ALARM) begin
        s = 0;
        alarm_wraps++;
      end else begin
        tone.playing = 1'b0;
        pattern_ends++;
        return;
      end
    end
    tone.step_index = s[1:0];
    tone.in_on_phase = 1'b1;
    phase_ms = beep_ms(tone.active_pattern, s);
  endtask

  task automatic sequence_request(input bps_in_t req, output bps_out_t res);
    logic bad_preset;
    bad_preset = 1'b0;
    case (req.req_type)
      REQ_TICK: begin
        if (tone.playing && !(tone.in_on_phase && phase_ms == DUR_FOREVER)) begin
          if (phase_ms > 1) begin
            phase_ms = phase_ms - 1'b1;
          end else if (tone.in_on_phase &&
                       gap_ms(tone.active_pattern, tone.step_index) != '0) begin
            tone.in_on_phase = 1'b0;
            phase_ms = gap_ms(tone.active_pattern, tone.step_index);
          end else begin
            next_beep();
          end
        end
      end
      REQ_PLAY: begin
        if (req.preset <= PAT_SOLID) begin
          tone.active_pattern = req.preset;
          tone.step_index = 2'd0;
          tone.in_on_phase = 1'b1;
          tone.playing = 1'b1;
          tone.held_volume = (req.volume > MAX_VOLUME) ? MAX_VOLUME : req.volume;
          phase_ms = beep_ms(req.preset, 0);
          plays++;
        end else begin
          tone.playing = 1'b0;
          bad_preset = 1'b1;
          invalid_plays++;
        end
      end
      REQ_STOP: begin
        tone.playing = 1'b0;
        stops++;
      end
      default: ;
    endcase
    res.buzzer_on = tone.playing && tone.in_on_phase;
    res.drive_volume = tone.held_volume;
    res.is_playing = tone.playing;
    res.status = bad_preset;
  endtask

  task automatic check_result(input bps_out_t got);
    bps_out_t want;
    if (predicted_outputs.size() == 0) begin
      failures++;
      if (failures <= 10) $display("Result with no request outstanding: %p", got);
      return;
    end
    want = predicted_outputs.pop_front();
    if (got.buzzer_on !== want.buzzer_on || got.drive_volume !== want.drive_volume ||
        got.is_playing !== want.is_playing || got.status !== want.status) begin
      failures++;
      if (failures <= 10)
        $display("Result %0d: expected on=%0b vol=%0d playing=%0b status=%0b, %s",
                 results_checked, want.buzzer_on, want.drive_volume, want.is_playing,
                 want.status,
                 $sformatf("got on=%0b vol=%0d playing=%0b status=%0b",
                           got.buzzer_on, got.drive_volume, got.is_playing, got.status));
    end
  endtask

  task automatic add_request(input logic [1:0] kind, input logic [2:0] p,
                             input logic [6:0] v);
    bps_in_t r;
    r.req_type = kind;
    r.preset = p;
    r.volume = v;
    request_queue.push_back(r);
    if (kind != REQ_UNUSED) requests_built++;
  endtask

  task automatic add_noise();
    case ($urandom_range(0, 3))
      0: add_request(REQ_STOP, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
      1: add_request(REQ_PLAY, 3'($urandom_range(5, 7)), 7'($urandom_range(0, 127)));
      2: add_request(REQ_UNUSED, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
      default: add_request(REQ_PLAY, 3'($urandom_range(0, 4)), 7'($urandom_range(0, 127)));
    endcase
  endtask

  // Mostly ticks, with the odd stray request to break a pattern mid-flight.
  task automatic add_ticks(input int n);
    repeat (n) begin
      if ($urandom_range(0, 149) == 0) add_noise();
      else add_request(REQ_TICK, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
    end
  endtask

  function automatic int tick_run();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 20);
      5, 6, 7:       return $urandom_range(21, 120);
      default:       return $urandom_range(121, 650);
    endcase
  endfunction

  task automatic build_stimulus();
    add_request(REQ_TICK, PAT_CHIRP, 7'd0);
    add_request(REQ_STOP, PAT_CHIRP, 7'd0);
    add_request(REQ_UNUSED, 3'd7, 7'd127);
    add_request(REQ_PLAY, PAT_CHIRP, 7'd0);
    add_request(REQ_TICK, 3'd7, 7'd127);
    add_request(REQ_PLAY, PAT_DOUBLE, 7'd100);
    add_request(REQ_PLAY, PAT_TRIPLE, 7'd101);
    add_request(REQ_PLAY, PAT_ALARM, 7'd127);
    add_request(REQ_UNUSED, PAT_CHIRP, 7'd0);
    add_request(REQ_PLAY, PAT_SOLID, 7'd64);
    add_request(REQ_TICK, PAT_CHIRP, 7'd0);
    add_request(REQ_TICK, PAT_CHIRP, 7'd0);
    add_request(REQ_STOP, 3'd7, 7'd127);
    add_request(REQ_STOP, PAT_CHIRP, 7'd0);
    add_request(REQ_PLAY, 3'd5, 7'd33);
    add_request(REQ_PLAY, PAT_SOLID, 7'd50);
    add_request(REQ_PLAY, 3'd6, 7'd0);
    add_request(REQ_PLAY, 3'd7, 7'd127);
    add_request(REQ_PLAY, PAT_ALARM, 7'd1);
    add_request(REQ_TICK, PAT_CHIRP, 7'd0);
    add_request(REQ_STOP, PAT_CHIRP, 7'd0);
    add_request(REQ_TICK, PAT_CHIRP, 7'd0);

    while (requests_built < REQUEST_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          add_request(REQ_PLAY, 3'($urandom_range(5, 7)), 7'($urandom_range(0, 127)));
          add_ticks($urandom_range(0, 20));
        end
        1: begin
          add_noise();
          add_ticks($urandom_range(0, 20));
        end
        default: begin
          add_request(REQ_PLAY, 3'($urandom_range(0, 4)), 7'($urandom_range(0, 127)));
          add_ticks(tick_run());
          if ($urandom_range(0, 2) == 0)
            add_request(REQ_STOP, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
        end
      endcase
    end
  endtask

  buzzer_pattern_sequencer #(
    .DURATION_BITS(DUR_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Request side: the prediction is made as each request is taken.
  always @(posedge clk) begin
    bps_out_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sequence_request(in_data, res);
        predicted_outputs.push_back(res);
        requests_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
          in_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          in_data <= request_queue.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
          send_wait <= send_burst ? 0 : $urandom_range(0, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: after each result the receiver holds off for a drawn number of cycles.
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      check_result(out_data);
      results_checked++;
      if ($urandom_range(0, 39) == 0) recv_burst <= !recv_burst;
      n = recv_burst ? 0 : $urandom_range(0, 12);
      recv_wait <= n;
      out_stall <= (n != 0);
    end else if (recv_wait > 0) begin
      recv_wait <= recv_wait - 1;
      out_stall <= (recv_wait > 1);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("buzzer_pattern_sequencer_test: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (request_queue.size() != 0 || in_valid || predicted_outputs.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (predicted_outputs.size() != 0) failures++;
    $display("Sent %0d requests: %0d plays, %0d with a bad preset, %0d stops;",
             requests_taken, plays, invalid_plays, stops);
    $display("%0d results checked. Patterns finished %0d times, the alarm wrapped %0d times.",
             results_checked, pattern_ends, alarm_wraps);
    if (failures == 0) begin
      $display("buzzer_pattern_sequencer_test: PASS");
    end else begin
      $display("buzzer_pattern_sequencer_test: FAIL");
    end
    $finish;
  end

endmodule
